@@ rtl/mhdw_pkg.sv @@
// ----------------------------------------------------------------------------
// mhdw_pkg
// Types and constants shared by the dependent memory walk block.
// ----------------------------------------------------------------------------
package mhdw_pkg;

	// Table geometry. Table and slot sizes are powers of two, so the slot
	// count is one too and a slot index is the low bits of a wider value.
	localparam int TABLE_BYTES = 65536;
	localparam int SLOT_BYTES  = 64;
	localparam int WALK_STEPS  = 64;

	localparam int TABLE_WORDS = TABLE_BYTES / 8;
	localparam int SLOT_COUNT  = TABLE_BYTES / SLOT_BYTES;
	localparam int WORD_W      = $clog2(TABLE_WORDS);
	localparam int SLOT_W      = $clog2(SLOT_COUNT);
	localparam int OFF_W       = $clog2(SLOT_BYTES);
	localparam int ADDR_W      = SLOT_W + OFF_W;
	localparam int OFF_MUL     = SLOT_BYTES - 8;

	// Field widths of the channels.
	localparam int LOAD_ADDR_W = 13;
	localparam int START_W     = 10;
	localparam int STEP_W      = 6;
	localparam int SLOT_OUT_W  = 10;

	// Mixing constants.
	localparam logic [31:0] MIX_MUL   = 32'h5bd1e995;
	localparam logic [63:0] NONCE_MUL = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] FNV_MUL   = 64'h0000000001000193;
	localparam logic [63:0] STEP_MUL  = 64'h517cc1b727220a95;

	// Only the low slot bits of the slot update survive the modulo.
	localparam logic [SLOT_W-1:0] NONCE_LO = NONCE_MUL[SLOT_W-1:0];
	localparam logic [SLOT_W-1:0] FNV_LO   = FNV_MUL[SLOT_W-1:0];
	localparam logic [SLOT_W-1:0] STEP_LO  = STEP_MUL[SLOT_W-1:0];

	// Item commands.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_WALK = 1'b1;

	typedef struct packed {
		logic                   cmd;
		logic [LOAD_ADDR_W-1:0] load_word_address;
		logic [63:0]            load_word;
		logic [63:0]            nonce;
		logic [START_W-1:0]     start_slot;
	} item_t;

	typedef struct packed {
		logic [STEP_W-1:0]     step_number;
		logic [SLOT_OUT_W-1:0] slot_index;
		logic [63:0]           merge_word;
		logic                  last;
	} result_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] addr;
		logic [63:0]       data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [WORD_W-1:0] addr;
	} rd_req_t;

endpackage

@@ rtl/mhdw_table.sv @@
// ----------------------------------------------------------------------------
// mhdw_table
// Table word store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mhdw_table (
	input  logic             clk,
	input  mhdw_pkg::wr_req_t wr,
	input  mhdw_pkg::rd_req_t rd,
	output logic [63:0]      rdata
);
	import mhdw_pkg::*;

	logic [63:0] mem [TABLE_WORDS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata <= mem[rd.addr];
		end
	end

endmodule

@@ rtl/mhdw_walk.sv @@
// ----------------------------------------------------------------------------
// mhdw_walk
// Item sequencer: table loads, step address generation, word assembly,
// mixing multiplies, slot update and the result register.
// ----------------------------------------------------------------------------
module mhdw_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mhdw_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output mhdw_pkg::result_t result,
	output mhdw_pkg::wr_req_t wr,
	output mhdw_pkg::rd_req_t rd,
	input  logic [63:0]       rdata
);
	import mhdw_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD0  = 3'd1;
	localparam logic [2:0] S_RD1  = 3'd2;
	localparam logic [2:0] S_MUL  = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [63:0]       prev_q;
	logic [SLOT_W-1:0] slot_q;
	logic [STEP_W-1:0] step_q;
	logic [SLOT_W-1:0] nmix_q;
	logic [WORD_W-1:0] word_q;
	logic [2:0]        byte_q;
	logic [63:0]       w0_q;
	logic [63:0]       p_lo_q;
	logic [31:0]       p_hi_q;
	logic              result_valid_q;
	result_t           result_q;

	logic                accept;
	logic                out_free;
	logic                emit;
	logic                last_step;
	logic [15:0]         ob;
	logic [16+OFF_W-1:0] off_prod;
	logic [ADDR_W-1:0]   byte_addr;
	logic [127:0]        pair;
	logic [63:0]         word;
	logic [63:0]         p_lo;
	logic [31:0]         p_hi;
	logic [63:0]         val;
	logic [SLOT_W-1:0]   mix_x;
	logic [SLOT_W-1:0]   next_slot;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;
	assign emit       = (state_q == S_EMIT) && out_free;
	assign last_step  = (step_q == STEP_W'(WALK_STEPS - 1));

	// Byte offset inside the slot from bits 24 to 39 of the previous value.
	assign ob        = prev_q[39:24];
	assign off_prod  = (16 + OFF_W)'(ob) * (16 + OFF_W)'(OFF_MUL);
	assign byte_addr = {slot_q, off_prod[16+OFF_W-1:16]};

	// The offset keeps all eight bytes inside the slot, so the second word
	// is only used when the byte offset is nonzero.
	assign pair = {rdata, w0_q};
	assign word = 64'(pair >> {byte_q, 3'b000});

	// The 64 by 32 product is split into two 32 by 32 halves.
	assign p_lo = word[31:0] * MIX_MUL;
	assign p_hi = word[63:32] * MIX_MUL;
	assign val  = p_lo_q + {p_hi_q, 32'b0} + 64'd1;

	assign mix_x     = val[SLOT_W-1:0] ^ nmix_q;
	assign next_slot = mix_x * FNV_LO + SLOT_W'(step_q) * STEP_LO;

	always_comb begin
		wr.en   = accept && (item.cmd == CMD_LOAD)
			&& (32'(item.load_word_address) < TABLE_WORDS);
		wr.addr = WORD_W'(item.load_word_address);
		wr.data = item.load_word;
	end

	always_comb begin
		rd.en   = (state_q == S_RD0) || (state_q == S_RD1);
		rd.addr = (state_q == S_RD0) ? byte_addr[ADDR_W-1:3] : word_q + WORD_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			prev_q         <= '0;
			slot_q         <= '0;
			step_q         <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && item.cmd == CMD_WALK) begin
						prev_q  <= item.nonce;
						slot_q  <= SLOT_W'(item.start_slot);
						step_q  <= '0;
						state_q <= S_RD0;
					end
				end
				S_RD0: state_q <= S_RD1;
				S_RD1: state_q <= S_MUL;
				S_MUL: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						prev_q  <= val;
						slot_q  <= next_slot;
						step_q  <= step_q + STEP_W'(1);
						state_q <= last_step ? S_IDLE : S_RD0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			nmix_q <= item.nonce[SLOT_W-1:0] * NONCE_LO;
		end
		if (state_q == S_RD0) begin
			word_q <= byte_addr[ADDR_W-1:3];
			byte_q <= byte_addr[2:0];
		end
		if (state_q == S_RD1) begin
			w0_q <= rdata;
		end
		if (state_q == S_MUL) begin
			p_lo_q <= p_lo;
			p_hi_q <= p_hi;
		end
		if (emit) begin
			result_q.step_number <= step_q;
			result_q.slot_index  <= SLOT_OUT_W'(slot_q);
			result_q.merge_word  <= val;
			result_q.last        <= last_step;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Table writes happen only between walks.
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_IDLE))
		else $error("table write during a walk");

	// Reads are issued only by the two read states.
	a_read_states: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> (state_q == S_RD0 || state_q == S_RD1))
		else $error("table read outside the read states");

	// The final step of a walk returns the sequencer to idle.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && last_step) |=> (state_q == S_IDLE))
		else $error("walk did not end after its final step");

	// A flagged last result always carries the final step number.
	a_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last) |->
			(result.step_number == STEP_W'(WALK_STEPS - 1)))
		else $error("last flag on a step other than the final one");

	// An emitted step shows up in the result register.
	a_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> result_valid)
		else $error("emitted step not held in the result register");

endmodule

@@ rtl/memory_hard_dependent_walk.sv @@
// ----------------------------------------------------------------------------
// memory_hard_dependent_walk
// Dependent walk over a loaded table of 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the item channel (item_valid, item_ready, item). A load
// item (cmd = 0) writes one table word in the cycle of its transfer and
// gives no result; the next item can follow in the next cycle. A walk item
// (cmd = 1) runs WALK_STEPS dependent steps and gives one result per step
// on the result channel (result_valid, result_ready, result), the final one
// flagged with last.
// Each step runs through the states RD0 and RD1, two reads of the single
// table read port for the unaligned word, then MUL for the split mixing
// multiply and EMIT to emit the result and form the next slot. The first
// result of a walk is registered in its first EMIT state, after RD0, RD1
// and MUL. No item is taken while a walk runs.
// When the receiver stalls, a step waits in its emit cycle until the result
// register is free; nothing is dropped. The last result of a walk can still
// wait while the next item is taken.
// Reset clears the sequencer and the walk state; the table holds no valid
// data after reset, and every word must be loaded before a walk reads it.
// ----------------------------------------------------------------------------
module memory_hard_dependent_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mhdw_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output mhdw_pkg::result_t result
);
	import mhdw_pkg::*;

	wr_req_t     wr;
	rd_req_t     rd;
	logic [63:0] rdata;

	mhdw_table u_table (
		.clk   (clk),
		.wr    (wr),
		.rd    (rd),
		.rdata (rdata)
	);

	mhdw_walk u_walk (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.wr           (wr),
		.rd           (rd),
		.rdata        (rdata)
	);

endmodule

@@ tb/sv/memory_hard_dependent_walk_tb.sv @@
// ----------------------------------------------------------------------------
// memory_hard_dependent_walk_tb
// Self-checking bench for the dependent memory walk. The whole table is
// preloaded so that no walk reads a word that was never written. A short
// table of directed loads and walks follows, then random loads and walks
// with random stalls on both channels. Every step result is compared with
// a predictor that keeps its own copy of the table and the walk state.
// ----------------------------------------------------------------------------
module memory_hard_dependent_walk_tb;
	import mhdw_pkg::*;

	localparam logic [63:0] MIX_K   = 64'h000000005bd1e995;
	localparam logic [63:0] NONCE_K = 64'h9e3779b97f4a7c15;
	localparam logic [63:0] FNV_K   = 64'h0000000001000193;
	localparam logic [63:0] STEP_K  = 64'h517cc1b727220a95;
	localparam int          SPAN_K  = SLOT_BYTES - 8;

	localparam int RANDOM_ITEMS = 110;
	localparam int TAIL_CYCLES  = 16;
	localparam int IDLE_LIMIT   = 4000;
	localparam int WORDS_PER_SLOT = SLOT_BYTES / 8;

	localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] ONES_MIXED = 64'hFFFF_FFFF_A42E_166C;

	typedef struct packed {
		logic                   cmd;
		logic [LOAD_ADDR_W-1:0] addr;
		logic [63:0]            word;
		logic [63:0]            nonce;
		logic [START_W-1:0]     slot;
		logic                   typed;
		result_t                first;
	} directed_row_t;

	// Slot 0 is preloaded with zeros and slot 1023 with ones, so the first
	// step of a walk that starts there can be written down directly.
	localparam int DIRECTED_ROWS = 16;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{CMD_LOAD, 13'd0,    64'd0, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_LOAD, 13'd8191, ONES,  64'd0, 10'd0, 1'b0, '0},
		'{CMD_LOAD, 13'h1555, 64'hAAAA_AAAA_AAAA_AAAA, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_LOAD, 13'h0AAA, 64'h5555_5555_5555_5555, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'd0, 10'd0, 1'b1,
			'{6'd0, 10'd0, 64'd1, 1'b0}},
		'{CMD_WALK, 13'd0, 64'd0, ONES, 10'd1023, 1'b1,
			'{6'd0, 10'd1023, ONES_MIXED, 1'b0}},
		'{CMD_LOAD, 13'd7, 64'h0123_4567_89AB_CDEF, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'h0000_0080_0000_0000, 10'd0, 1'b1,
			'{6'd0, 10'd0, 64'd1, 1'b0}},
		'{CMD_WALK, 13'd0, 64'd0, 64'h0000_00FF_FF00_0000, 10'd0, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'h5555_5555_5555_5555, 10'h155, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 10'h2AA, 1'b0, '0},
		'{CMD_LOAD, 13'd4096, 64'h8000_0000_0000_0001, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'h8000_0000_0000_0001, 10'd512, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'h0000_0000_00FF_FFFF, 10'd1023, 1'b1,
			'{6'd0, 10'd1023, ONES_MIXED, 1'b0}},
		'{CMD_LOAD, 13'd100, 64'hFFFF_FFFF_0000_0000, 64'd0, 10'd0, 1'b0, '0},
		'{CMD_WALK, 13'd0, 64'd0, 64'd1, 10'd12, 1'b0, '0}
	};

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	memory_hard_dependent_walk dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: a shadow of the table and the walk registers.
	logic [63:0]       table_shadow [TABLE_WORDS];
	logic [63:0]       walk_prev;
	logic [SLOT_W-1:0] walk_slot;
	logic [STEP_W-1:0] walk_steps_done;
	result_t           steps_due [$];
	result_t           due_step;

	int  mismatches;
	int  loads_sent;
	int  walks_sent;
	int  results_seen;
	int  idle_cycles;
	int  ready_hold;
	bit  quiet_spell;

	task automatic flag_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] fetch_unaligned(input logic [ADDR_W-1:0] byte_addr);
		logic [WORD_W-1:0] w;
		logic [127:0]      pair;
		w = byte_addr[ADDR_W-1:3];
		if (byte_addr[2:0] == 3'd0)
			return table_shadow[w];
		// The offset never passes byte 55 of a slot, so w + 1 stays in the slot.
		pair = {table_shadow[w + 1'b1], table_shadow[w]};
		pair = pair >> (8 * byte_addr[2:0]);
		return pair[63:0];
	endfunction

	task automatic predict_walk(input logic [63:0] nonce, input logic [START_W-1:0] start);
		logic [63:0]       nonce_mix;
		logic [63:0]       val;
		logic [63:0]       next_slot;
		logic [31:0]       span;
		logic [ADDR_W-1:0] byte_addr;
		result_t           r;
		nonce_mix = nonce * NONCE_K;
		walk_prev = nonce;
		walk_slot = SLOT_W'(start % SLOT_COUNT);
		walk_steps_done = '0;
		for (int s = 0; s < WALK_STEPS; s++) begin
			span = (32'(walk_prev[39:24]) * SPAN_K) >> 16;
			byte_addr = ADDR_W'(32'(walk_slot) * SLOT_BYTES + span);
			val = fetch_unaligned(byte_addr) * MIX_K + 64'd1;
			r.step_number = STEP_W'(s);
			r.slot_index = SLOT_OUT_W'(walk_slot);
			r.merge_word = val;
			r.last = (s == WALK_STEPS - 1);
			steps_due.push_back(r);
			next_slot = (val ^ nonce_mix) * FNV_K + 64'(s) * STEP_K;
			walk_slot = SLOT_W'(next_slot % SLOT_COUNT);
			walk_prev = val;
			walk_steps_done = walk_steps_done + 1'b1;
		end
	endtask

	task automatic apply_item(input item_t it);
		if (it.cmd == CMD_LOAD) begin
			if (it.load_word_address < TABLE_WORDS)
				table_shadow[it.load_word_address] = it.load_word;
			loads_sent++;
		end else begin
			predict_walk(it.nonce, it.start_slot);
			walks_sent++;
		end
	endtask

	task automatic send_item(input item_t it);
		int gap;
		gap = (quiet_spell || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		apply_item(it);
	endtask

	task automatic hold_until_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (steps_due.size() != 0)
			@(negedge clk);
	endtask

	// Result side: random stalls, switched off during quiet spells.
	initial begin
		result_ready = 1'b0;
		ready_hold = 0;
		forever begin
			@(negedge clk);
			if (ready_hold > 0) begin
				ready_hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (!quiet_spell && $urandom_range(0, 99) < 20)
					ready_hold = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			results_seen++;
			if (steps_due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result: step %0d slot %0d word %h",
					result.step_number, result.slot_index, result.merge_word));
			end else begin
				due_step = steps_due.pop_front();
				if (result.step_number !== due_step.step_number)
					flag_mismatch($sformatf("step_number %0d, expected %0d",
						result.step_number, due_step.step_number));
				if (result.slot_index !== due_step.slot_index)
					flag_mismatch($sformatf("step %0d: slot_index %0d, expected %0d",
						due_step.step_number, result.slot_index, due_step.slot_index));
				if (result.merge_word !== due_step.merge_word)
					flag_mismatch($sformatf("step %0d: merge_word %h, expected %h",
						due_step.step_number, result.merge_word, due_step.merge_word));
				if (result.last !== due_step.last)
					flag_mismatch($sformatf("step %0d: last %b, expected %b",
						due_step.step_number, result.last, due_step.last));
			end
		end
	end

	// Watchdog: ends the run when no transfer happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("[%0t] timeout: no transfer for %0d cycles, %0d results pending",
					$realtime, IDLE_LIMIT, steps_due.size());
				$display("memory_hard_dependent_walk_tb failed");
				$finish;
			end
		end
	end

	initial begin
		item_t            it;
		logic [SLOT_W-1:0] focus_slot;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		quiet_spell = 1'b1;
		mismatches = 0;
		loads_sent = 0;
		walks_sent = 0;
		results_seen = 0;
		idle_cycles = 0;
		walk_prev = '0;
		walk_slot = '0;
		walk_steps_done = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Fill the whole table first; the ignored fields carry noise.
		for (int w = 0; w < TABLE_WORDS; w++) begin
			it.cmd = CMD_LOAD;
			it.load_word_address = LOAD_ADDR_W'(w);
			if (w < WORDS_PER_SLOT)
				it.load_word = '0;
			else if (w >= TABLE_WORDS - WORDS_PER_SLOT)
				it.load_word = ONES;
			else
				it.load_word = rand64();
			it.nonce = rand64();
			it.start_slot = START_W'($urandom());
			send_item(it);
		end

		quiet_spell = 1'b0;
		for (int i = 0; i < DIRECTED_ROWS; i++) begin
			it.cmd = DIRECTED[i].cmd;
			it.load_word_address = DIRECTED[i].addr;
			it.load_word = DIRECTED[i].word;
			it.nonce = DIRECTED[i].nonce;
			it.start_slot = DIRECTED[i].slot;
			send_item(it);
			// The typed first step replaces the predicted one for this walk.
			if (DIRECTED[i].typed)
				steps_due[steps_due.size() - WALK_STEPS] = DIRECTED[i].first;
		end
		hold_until_drained();

		// Random part: loads cluster on a focus slot that walks then start from.
		focus_slot = SLOT_W'($urandom());
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 20 == 10)
				quiet_spell = !quiet_spell;
			if (n == 40 || n == 80)
				hold_until_drained();
			if ($urandom_range(0, 9) == 0)
				focus_slot = SLOT_W'($urandom());
			it.nonce = rand64();
			it.load_word = rand64();
			it.start_slot = START_W'($urandom());
			it.load_word_address = LOAD_ADDR_W'($urandom());
			if ($urandom_range(0, 99) < 45) begin
				it.cmd = CMD_WALK;
				if ($urandom_range(0, 1))
					it.start_slot = START_W'(focus_slot);
			end else begin
				it.cmd = CMD_LOAD;
				if ($urandom_range(0, 1))
					it.load_word_address = LOAD_ADDR_W'(32'(focus_slot) * WORDS_PER_SLOT
						+ $urandom_range(0, WORDS_PER_SLOT - 1));
			end
			send_item(it);
		end

		@(negedge clk);
		item_valid <= 1'b0;
		while (steps_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d table loads and %0d walks; %0d step results compared.",
			loads_sent, walks_sent, results_seen);
		$display("Mismatches found: %0d.", mismatches);
		if (mismatches == 0)
			$display("memory_hard_dependent_walk_tb passed");
		else
			$display("memory_hard_dependent_walk_tb failed");
		$finish;
	end

endmodule
